@@ sv/oipa_pkg.sv @@
// shared constants and types for the ordered id pool allocator
package oipa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int ID_W       = $clog2(POOL_DEPTH);
  localparam int LINK_W     = ID_W + 1;
  localparam int CNT_W      = 11;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);
  localparam logic [ID_W-1:0]   ID_LAST   = ID_W'(POOL_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_INIT      = 2'd0,
    OP_ALLOC_CNT = 2'd1,
    OP_ALLOC_ID  = 2'd2,
    OP_RELEASE   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD_ID = 2'd1,
    STAT_SHORT  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RD,
    S_APPEND_TAIL,
    S_CNT_CHK,
    S_CNT_WR
  } state_e;

endpackage

@@ sv/oipa_ram.sv @@
// single-port-write, single-port-read ram with registered read data
module oipa_ram #(
  parameter int Width = 11,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/ordered_id_pool_allocator.sv @@
// ordered free-id pool: doubly linked free list held in link and mark memories
//
// After reset the block runs a clearing pass of the free-mark memory with busy_o
// high; start_i is ignored until it ends. An op is taken when start_i is high and
// busy_o low, and exactly one result is shown on done_o for one cycle.
// Init sweeps all 1024 entries, one per cycle.
// Allocate-named and release read the mark and links, then write back; a release
// appending behind an existing tail costs one more write to the next-link memory.
// Allocate-count reads and then writes each head entry in turn, once per id removed.
// The receiver cannot stall: a result not taken is lost.
module ordered_id_pool_allocator
  import oipa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ID_W-1:0]      cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           op_i,
  input  logic [CNT_W-1:0]     alloc_count_i,
  input  logic [ID_W-1:0]      res_id_i,
  output logic                 done_o,
  output logic [ID_W-1:0]      head_id_o,
  output logic                 pool_empty_o,
  output logic [STAT_W-1:0]    status_o
);

  state_e             state_q, state_d;
  logic [ID_W-1:0]    range_low_q, range_high_q;
  logic [ID_W-1:0]    sweep_q, sweep_d;
  logic               init_q, init_d;
  logic [LINK_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ID_W-1:0]    id_q, id_d;
  op_e                op_q, op_d;
  logic               done_q, done_d;
  logic [ID_W-1:0]    head_out_q;
  logic               empty_q;
  status_e            status_q, fin_status;

  logic               accept;
  logic               fin;
  logic               nx_we, pv_we, mk_we;
  logic [ID_W-1:0]    nx_wa, pv_wa, mk_wa, rd_addr;
  logic [LINK_W-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;
  logic               mk_wd, mk_rd;
  logic               in_range;
  logic [LINK_W-1:0]  k_ext;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign rd_addr = (state_q == S_IDLE) ? res_id_i : head_q[ID_W-1:0];
  assign k_ext = {1'b0, sweep_q};
  assign in_range = init_q && (sweep_q >= range_low_q) && (sweep_q <= range_high_q);

  oipa_ram #(.Width(LINK_W), .Depth(POOL_DEPTH)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(rd_addr), .rdata_o(nx_rd)
  );
  oipa_ram #(.Width(LINK_W), .Depth(POOL_DEPTH)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(rd_addr), .rdata_o(pv_rd)
  );
  oipa_ram #(.Width(1), .Depth(POOL_DEPTH)) u_mark (
    .clk_i, .we_i(mk_we), .waddr_i(mk_wa), .wdata_i(mk_wd),
    .raddr_i(rd_addr), .rdata_o(mk_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (sweep_q == ID_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_INIT:      state_d = S_SWEEP;
            OP_ALLOC_CNT: state_d = (alloc_count_i == '0) ? S_IDLE : S_CNT_CHK;
            OP_ALLOC_ID,
            OP_RELEASE:   state_d = S_RD;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (op_q == OP_RELEASE && !mk_rd && tail_q != LINK_NULL) state_d = S_APPEND_TAIL;
        else state_d = S_IDLE;
      end
      S_APPEND_TAIL: state_d = S_IDLE;
      S_CNT_CHK: state_d = (head_q == LINK_NULL) ? S_IDLE : S_CNT_WR;
      S_CNT_WR:  state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_CNT_CHK;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    sweep_d = sweep_q;
    init_d = init_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    id_d = id_q;
    op_d = op_q;
    fin = 1'b0;
    fin_status = STAT_OK;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    mk_we = 1'b0; mk_wa = '0; mk_wd = 1'b0;
    unique case (state_q)
      S_SWEEP: begin
        mk_we = 1'b1; mk_wa = sweep_q; mk_wd = in_range;
        nx_we = 1'b1; nx_wa = sweep_q;
        nx_wd = (sweep_q == range_high_q) ? LINK_NULL : k_ext + LINK_W'(1);
        pv_we = 1'b1; pv_wa = sweep_q;
        pv_wd = (sweep_q == range_low_q) ? LINK_NULL : k_ext - LINK_W'(1);
        sweep_d = sweep_q + ID_W'(1);
        if (sweep_q == ID_LAST) begin
          fin = init_q;
          if (init_q && range_low_q <= range_high_q) begin
            head_d = {1'b0, range_low_q};
            tail_d = {1'b0, range_high_q};
          end else begin
            head_d = LINK_NULL;
            tail_d = LINK_NULL;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(op_i);
          id_d = res_id_i;
          cnt_d = alloc_count_i;
          if (op_e'(op_i) == OP_INIT) begin
            init_d = 1'b1;
            sweep_d = '0;
          end
          if (op_e'(op_i) == OP_ALLOC_CNT && alloc_count_i == '0) fin = 1'b1;
        end
      end
      S_RD: begin
        if (op_q == OP_ALLOC_ID) begin
          fin = 1'b1;
          if (!mk_rd) begin
            fin_status = STAT_BAD_ID;
          end else begin
            mk_we = 1'b1; mk_wa = id_q; mk_wd = 1'b0;
            if (pv_rd != LINK_NULL) begin
              nx_we = 1'b1; nx_wa = pv_rd[ID_W-1:0]; nx_wd = nx_rd;
            end else begin
              head_d = nx_rd;
            end
            if (nx_rd != LINK_NULL) begin
              pv_we = 1'b1; pv_wa = nx_rd[ID_W-1:0]; pv_wd = pv_rd;
            end else begin
              tail_d = pv_rd;
            end
          end
        end else begin
          if (mk_rd) begin
            fin = 1'b1;
            fin_status = STAT_BAD_ID;
          end else begin
            mk_we = 1'b1; mk_wa = id_q; mk_wd = 1'b1;
            pv_we = 1'b1; pv_wa = id_q; pv_wd = tail_q;
            nx_we = 1'b1; nx_wa = id_q; nx_wd = LINK_NULL;
            // empty list: the id becomes both ends now
            if (tail_q == LINK_NULL) begin
              head_d = {1'b0, id_q};
              tail_d = {1'b0, id_q};
              fin = 1'b1;
            end
          end
        end
      end
      S_APPEND_TAIL: begin
        nx_we = 1'b1; nx_wa = tail_q[ID_W-1:0]; nx_wd = {1'b0, id_q};
        tail_d = {1'b0, id_q};
        fin = 1'b1;
      end
      S_CNT_CHK: begin
        if (head_q == LINK_NULL) begin
          fin = 1'b1;
          fin_status = STAT_SHORT;
        end
      end
      S_CNT_WR: begin
        mk_we = 1'b1; mk_wa = head_q[ID_W-1:0]; mk_wd = 1'b0;
        if (nx_rd != LINK_NULL) begin
          pv_we = 1'b1; pv_wa = nx_rd[ID_W-1:0]; pv_wd = LINK_NULL;
        end else begin
          tail_d = LINK_NULL;
        end
        head_d = nx_rd;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) fin = 1'b1;
      end
      default: ;
    endcase
    done_d = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      init_q <= 1'b0;
      head_q <= LINK_NULL;
      tail_q <= LINK_NULL;
      done_q <= 1'b0;
      range_low_q <= '0;
      range_high_q <= ID_LAST;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      init_q <= init_d;
      head_q <= head_d;
      tail_q <= tail_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_RANGE_LOW:  range_low_q <= cfg_data_i;
          REG_RANGE_HIGH: range_high_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    id_q <= id_d;
    op_q <= op_d;
    if (fin) begin
      head_out_q <= (head_d == LINK_NULL) ? '0 : head_d[ID_W-1:0];
      empty_q <= (head_d == LINK_NULL);
      status_q <= fin_status;
    end
  end

  assign done_o = done_q;
  assign head_id_o = head_out_q;
  assign pool_empty_o = empty_q;
  assign status_o = status_q;

endmodule
